### sv/goldbach_pair_finder_assert.svh
// Assertion macros shared by the goldbach pair finder RTL
`ifndef GOLDBACH_PAIR_FINDER_ASSERT_SVH
`define GOLDBACH_PAIR_FINDER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define GPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/gpf_pkg.sv
// Shared types and constants for the goldbach pair finder
`default_nettype none

package gpf_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 16;
    localparam int unsigned SMALLEST_PRIME  = 2;
    localparam int unsigned SMALLEST_SUM    = 4;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_RESULT,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

### sv/gpf_front.sv
// Front end: accepts input beats and keeps only even numbers that can split
`default_nettype none

module gpf_front #(
    parameter int unsigned VALUE_WIDTH = gpf_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   value_valid,
    output logic                        value_stall,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire gpf_pkg::queue_status_t q_status,
    output logic                        push,
    output logic [VALUE_WIDTH-1:0]      push_data
);

    logic keep;

    // drop odd numbers and those below the smallest sum of two primes
    assign keep        = !value[0] && (value >= VALUE_WIDTH'(gpf_pkg::SMALLEST_SUM));
    assign value_stall = q_status.full;
    assign push        = value_valid && !q_status.full && keep;
    assign push_data   = value;

endmodule

`default_nettype wire

### sv/gpf_queue.sv
// Short queue between front end and search engine
`default_nettype none

`include "goldbach_pair_finder_assert.svh"

module gpf_queue #(
    parameter int unsigned VALUE_WIDTH = gpf_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire logic [VALUE_WIDTH-1:0] push_data,
    input  wire logic                   pop,
    output logic [VALUE_WIDTH-1:0]      pop_data,
    output gpf_pkg::queue_status_t      q_status
);

    logic [VALUE_WIDTH-1:0]          mem_reg [gpf_pkg::QUEUE_DEPTH];
    logic [gpf_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [gpf_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [gpf_pkg::QCNT_W-1:0]      count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + gpf_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + gpf_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + gpf_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - gpf_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data           = mem_reg[rd_ptr_reg];
    assign q_status.not_empty = (count_reg != '0);
    assign q_status.full      = (count_reg == gpf_pkg::QCNT_W'(gpf_pkg::QUEUE_DEPTH));

    `GPF_ASSERT_NOW(a_no_overfill, 1'b1, count_reg <= gpf_pkg::QCNT_W'(gpf_pkg::QUEUE_DEPTH), "queue count above depth")
    `GPF_ASSERT_NOW(a_no_push_full, push, !q_status.full, "push into full queue")
    `GPF_ASSERT_NOW(a_no_pop_empty, pop, q_status.not_empty, "pop from empty queue")

endmodule

`default_nettype wire

### sv/gpf_back.sv
// Search engine: candidate sweep with a shared bit-serial remainder unit
`default_nettype none

`include "goldbach_pair_finder_assert.svh"

module gpf_back #(
    parameter int unsigned VALUE_WIDTH = gpf_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire gpf_pkg::queue_status_t q_status,
    input  wire logic [VALUE_WIDTH-1:0] q_data,
    output logic                        pop,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic [VALUE_WIDTH-1:0]      number,
    output logic [VALUE_WIDTH-1:0]      small_prime,
    output logic [VALUE_WIDTH-1:0]      large_prime
);

    localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

    gpf_pkg::back_state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] p_reg, p_next;
    logic [VALUE_WIDTH-1:0] m_reg, m_next;
    logic [VALUE_WIDTH-1:0] k_reg, k_next;
    logic [VALUE_WIDTH:0]   sq_reg, sq_next;
    logic [VALUE_WIDTH:0]   rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   phase_reg, phase_next;

    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_n_reg, out_n_next;
    logic [VALUE_WIDTH-1:0] out_p_reg, out_p_next;
    logic [VALUE_WIDTH-1:0] out_q_reg, out_q_next;

    logic                   sq_over;
    logic                   at_half;
    logic                   out_free;
    logic [VALUE_WIDTH:0]   rem_shift;
    logic [VALUE_WIDTH:0]   k_ext;

    assign sq_over   = sq_reg > {1'b0, m_reg};
    assign at_half   = p_reg >= (n_reg >> 1);
    assign out_free  = !out_valid_reg || !result_stall;
    assign rem_shift = {rem_reg[VALUE_WIDTH-1:0], dvd_reg[VALUE_WIDTH-1]};
    assign k_ext     = {1'b0, k_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gpf_pkg::ST_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    state_next = gpf_pkg::ST_CHECK;
                end
            end
            gpf_pkg::ST_CHECK:
            begin
                if (!sq_over)
                begin
                    state_next = gpf_pkg::ST_DIV;
                end
                else if (phase_reg)
                begin
                    state_next = gpf_pkg::ST_EMIT;
                end
            end
            gpf_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = gpf_pkg::ST_RESULT;
                end
            end
            gpf_pkg::ST_RESULT:
            begin
                if (rem_reg == '0 && at_half)
                begin
                    state_next = gpf_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = gpf_pkg::ST_CHECK;
                end
            end
            gpf_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = gpf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gpf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        n_next         = n_reg;
        p_next         = p_reg;
        m_next         = m_reg;
        k_next         = k_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_n_next     = out_n_reg;
        out_p_next     = out_p_reg;
        out_q_next     = out_q_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            gpf_pkg::ST_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    pop        = 1'b1;
                    n_next     = q_data;
                    p_next     = VALUE_WIDTH'(gpf_pkg::SMALLEST_PRIME);
                    m_next     = VALUE_WIDTH'(gpf_pkg::SMALLEST_PRIME);
                    k_next     = VALUE_WIDTH'(gpf_pkg::SMALLEST_PRIME);
                    sq_next    = (VALUE_WIDTH + 1)'(gpf_pkg::SMALLEST_PRIME
                                                    * gpf_pkg::SMALLEST_PRIME);
                    phase_next = 1'b0;
                end
            end
            gpf_pkg::ST_CHECK:
            begin
                if (!sq_over)
                begin
                    rem_next = '0;
                    dvd_next = m_reg;
                    cnt_next = CNT_W'(VALUE_WIDTH - 1);
                end
                else if (!phase_reg)
                begin
                    // candidate is prime, test its complement
                    phase_next = 1'b1;
                    m_next     = n_reg - p_reg;
                    k_next     = VALUE_WIDTH'(gpf_pkg::SMALLEST_PRIME);
                    sq_next    = (VALUE_WIDTH + 1)'(gpf_pkg::SMALLEST_PRIME
                                                    * gpf_pkg::SMALLEST_PRIME);
                end
            end
            gpf_pkg::ST_DIV:
            begin
                rem_next = (rem_shift >= k_ext) ? (rem_shift - k_ext) : rem_shift;
                dvd_next = {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            gpf_pkg::ST_RESULT:
            begin
                if (rem_reg == '0)
                begin
                    // composite: advance to next candidate
                    p_next     = p_reg + VALUE_WIDTH'(1);
                    m_next     = p_reg + VALUE_WIDTH'(1);
                    phase_next = 1'b0;
                    k_next     = VALUE_WIDTH'(gpf_pkg::SMALLEST_PRIME);
                    sq_next    = (VALUE_WIDTH + 1)'(gpf_pkg::SMALLEST_PRIME
                                                    * gpf_pkg::SMALLEST_PRIME);
                end
                else
                begin
                    k_next  = k_reg + VALUE_WIDTH'(1);
                    sq_next = sq_reg + {k_reg, 1'b1};
                end
            end
            gpf_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_n_next     = n_reg;
                    out_p_next     = p_reg;
                    out_q_next     = m_reg;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gpf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        p_reg     <= p_next;
        m_reg     <= m_next;
        k_reg     <= k_next;
        sq_reg    <= sq_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        cnt_reg   <= cnt_next;
        phase_reg <= phase_next;
        out_n_reg <= out_n_next;
        out_p_reg <= out_p_next;
        out_q_reg <= out_q_next;
    end

    assign result_valid = out_valid_reg;
    assign number       = out_n_reg;
    assign small_prime  = out_p_reg;
    assign large_prime  = out_q_reg;

    `GPF_ASSERT_NOW(a_sum_matches, out_valid_reg, ({1'b0, out_p_reg} + {1'b0, out_q_reg}) == {1'b0, out_n_reg}, "primes do not sum to number")
    `GPF_ASSERT_NOW(a_pair_ordered, out_valid_reg, out_p_reg <= out_q_reg, "small prime above large prime")
    `GPF_ASSERT_NOW(a_emit_after_both, state_reg == gpf_pkg::ST_EMIT, phase_reg, "emit before complement tested")

endmodule

`default_nettype wire

### sv/goldbach_pair_finder.sv
// Goldbach pair finder top level: front end, queue and search engine
//
// Input channel: value with value_valid / value_stall. A beat is taken when
// value_valid is high and value_stall is low. Odd values and values below
// four are dropped at once and give no result.
// Output channel: number, small_prime, large_prime with result_valid /
// result_stall. One beat per even value that splits into two primes; the
// smallest such small_prime is reported, large_prime = number - small_prime.
// A two-entry queue sits between input and search engine, so up to two even
// values are taken while the engine works or a result waits to be taken.
// Each candidate prime test tries divisors k = 2, 3, 4 and upward while
// k*k <= m, each division going through ST_CHECK, ST_DIV and ST_RESULT in
// the single shared bit-serial remainder unit; a test that finds a prime
// closes in ST_CHECK. The value leaves the queue in ST_IDLE, the output
// register is loaded in ST_EMIT and result_valid rises the cycle after.
// Items are searched one at a time, so throughput is set by that divider loop.
// When result_stall is high the finished result holds in the output register;
// the engine waits in ST_EMIT; the queue then fills and raises value_stall.
// Reset clears the queue, the engine state and the output valid.
`default_nettype none

module goldbach_pair_finder #(
    parameter int unsigned VALUE_WIDTH = gpf_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   value_valid,
    output logic                        value_stall,
    input  wire logic [VALUE_WIDTH-1:0] value,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic [VALUE_WIDTH-1:0]      number,
    output logic [VALUE_WIDTH-1:0]      small_prime,
    output logic [VALUE_WIDTH-1:0]      large_prime
);

    gpf_pkg::queue_status_t q_status;
    logic                   push;
    logic [VALUE_WIDTH-1:0] push_data;
    logic                   pop;
    logic [VALUE_WIDTH-1:0] pop_data;

    gpf_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .q_status    (q_status),
        .push        (push),
        .push_data   (push_data)
    );

    gpf_queue #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    gpf_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_data       (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .number       (number),
        .small_prime  (small_prime),
        .large_prime  (large_prime)
    );

endmodule

`default_nettype wire
